// ----- hdl/urbif_pkg.sv -----
package urbif_pkg;

    localparam int RX_DEPTH_DEF = 256;
    localparam int TX_DEPTH_DEF = 256;

    localparam logic [7:0] BYTE_MAX = 8'hFF;

    localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
    localparam logic [2:0] KIND_IDLE     = 3'd1;
    localparam logic [2:0] KIND_TX_EMPTY = 3'd2;
    localparam logic [2:0] KIND_PUSH     = 3'd3;
    localparam logic [2:0] KIND_POP      = 3'd4;
    localparam logic [2:0] KIND_CLEAR    = 3'd5;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_RX_DROPPED = 2'd1;
    localparam logic [1:0] ST_TX_REFUSED = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       end_of_block;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] line_byte;
        logic       line_byte_valid;
        logic [7:0] host_byte;
        logic       host_byte_valid;
        logic [7:0] frame_length;
        logic       frame_done;
        logic       sending;
    } t_out_item;

endpackage

// ----- hdl/uart_ring_buffers_idle_frame.sv -----
// UART receive and transmit rings with idle-line frame length. Each request is one event
// (line byte, line idle, transmitter empty, host push, host pop, flag clear) and yields
// exactly one result. In the cycle a request is accepted, the entry at each ring's read
// pointer is read from its memory, and in the following cycle the event is applied, the
// memory written back and the result registered; the input stalls during that execute
// cycle and while a stalled result is held, so no new request is taken before the last
// one is applied. Each ring holds one byte less than its depth; a full receive ring
// drops the byte and a full transmit ring refuses the push and starts the drain. Storage
// has no reset and needs no clearing pass; pointers and flags clear on reset.
module uart_ring_buffers_idle_frame #(
    parameter int RX_DEPTH = urbif_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbif_pkg::TX_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  urbif_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output urbif_pkg::t_out_item o_out_item
);
    import urbif_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [RX_AW-1:0] r_rx_rd, n_rx_rd, r_rx_wr, n_rx_wr;
    logic [TX_AW-1:0] r_tx_rd, n_tx_rd, r_tx_wr, n_tx_wr;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [7:0]       r_len, n_len;
    logic             r_exec;
    logic             r_out_valid;
    t_in_item         r_item;
    t_out_item        r_out, n_out;
    logic [7:0]       r_rx_q, r_tx_q;
    logic             rx_we, tx_we;
    logic             accept;

    logic [RX_AW-1:0] rx_wr_nxt, rx_rd_nxt;
    logic [TX_AW-1:0] tx_wr_nxt, tx_rd_nxt;
    logic [RX_AW:0]   rx_occ;

    assign o_in_stall  = r_exec || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        rx_wr_nxt = (r_rx_wr == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_wr + 1'b1;
        rx_rd_nxt = (r_rx_rd == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_rd + 1'b1;
        tx_wr_nxt = (r_tx_wr == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + 1'b1;
        tx_rd_nxt = (r_tx_rd == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + 1'b1;
        if (r_rx_wr >= r_rx_rd) begin
            rx_occ = {1'b0, r_rx_wr} - {1'b0, r_rx_rd};
        end else begin
            rx_occ = {1'b0, r_rx_wr} + (RX_AW+1)'(RX_DEPTH) - {1'b0, r_rx_rd};
        end
    end

    always_comb begin
        n_rx_rd = r_rx_rd;
        n_rx_wr = r_rx_wr;
        n_tx_rd = r_tx_rd;
        n_tx_wr = r_tx_wr;
        n_busy  = r_busy;
        n_done  = r_done;
        n_len   = r_len;
        rx_we   = 1'b0;
        tx_we   = 1'b0;
        n_out   = '0;
        case (r_item.kind)
            KIND_RX_BYTE: begin
                if (rx_wr_nxt != r_rx_rd) begin
                    rx_we   = 1'b1;
                    n_rx_wr = rx_wr_nxt;
                end else begin
                    n_out.status = ST_RX_DROPPED;
                end
            end
            KIND_IDLE: begin
                n_done = 1'b1;
                if (32'(rx_occ) > 32'(BYTE_MAX)) begin
                    n_len = BYTE_MAX;
                end else begin
                    n_len = 8'(rx_occ);
                end
            end
            KIND_TX_EMPTY: begin
                if (r_busy) begin
                    if (r_tx_rd != r_tx_wr) begin
                        n_out.line_byte       = r_tx_q;
                        n_out.line_byte_valid = 1'b1;
                        n_tx_rd               = tx_rd_nxt;
                    end else begin
                        n_busy       = 1'b0;
                        n_out.status = ST_EMPTY;
                    end
                end
            end
            KIND_PUSH: begin
                if (tx_wr_nxt == r_tx_rd) begin
                    n_busy       = 1'b1;
                    n_out.status = ST_TX_REFUSED;
                end else begin
                    tx_we   = 1'b1;
                    n_tx_wr = tx_wr_nxt;
                    if (r_item.end_of_block) begin
                        n_busy = 1'b1;
                    end
                end
            end
            KIND_POP: begin
                if (r_rx_rd != r_rx_wr) begin
                    n_out.host_byte       = r_rx_q;
                    n_out.host_byte_valid = 1'b1;
                    n_rx_rd               = rx_rd_nxt;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            KIND_CLEAR: begin
                n_done = 1'b0;
                n_len  = '0;
            end
            default: begin
            end
        endcase
        n_out.frame_length = n_len;
        n_out.frame_done   = n_done;
        n_out.sending      = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx_q <= rx_mem[r_rx_rd];
        end
        if (r_exec && rx_we) begin
            rx_mem[r_rx_wr] <= r_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_q <= tx_mem[r_tx_rd];
        end
        if (r_exec && tx_we) begin
            tx_mem[r_tx_wr] <= r_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        if (r_exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_rd     <= '0;
            r_rx_wr     <= '0;
            r_tx_rd     <= '0;
            r_tx_wr     <= '0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_len       <= '0;
            r_exec      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_exec <= accept;
            if (r_exec) begin
                r_rx_rd     <= n_rx_rd;
                r_rx_wr     <= n_rx_wr;
                r_tx_rd     <= n_tx_rd;
                r_tx_wr     <= n_tx_wr;
                r_busy      <= n_busy;
                r_done      <= n_done;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/urbif_checker.sv -----
module urbif_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input urbif_pkg::t_out_item o_out_item
);
    import urbif_pkg::*;

    logic acc;
    assign acc = i_in_valid && !o_in_stall;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_in_stall)
        else $error("request accepted while previous one in progress");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 o_out_valid)
        else $error("no result two cycles after request");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.line_byte_valid || o_out_item.host_byte_valid)) |->
        (o_out_item.status == ST_DONE &&
         !(o_out_item.line_byte_valid && o_out_item.host_byte_valid)))
        else $error("byte returned with failure status");

endmodule

bind uart_ring_buffers_idle_frame urbif_checker u_urbif_checker (.*);
